// ===== rtl/core/qrs_pkg.sv =====
`timescale 1ns / 1ps

package qrs_pkg;

  // Data path word: signed fixed point with 24 fraction bits.
  localparam int DATA_W    = 64;
  localparam int FRAC_BITS = 24;

  // Configuration registers.
  localparam int TOL_W       = 12;
  localparam int WHITE_W     = 8;
  localparam int CFG_DATA_W  = 12;
  localparam int CFG_IDX_W   = 2;
  localparam logic [TOL_W-1:0]   TOL_RESET   = 12'd25;
  localparam logic [WHITE_W-1:0] WHITE_RESET = 8'd20;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 2'd1;

  // Saturation limits.
  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Operation carried by each input word.
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SCORE = 2'd2,
    OP_CLOSE = 2'd3
  } op_t;

  // Magnitude of a signed word; the most negative value maps to 2^63.
  function automatic logic [DATA_W-1:0] umag(input logic signed [DATA_W-1:0] v);
    logic [DATA_W-1:0] r;
    r = v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    return r;
  endfunction

  // Saturating addition.
  function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] p,
                                                       input logic signed [DATA_W-1:0] q);
    logic signed [DATA_W-1:0] s;
    s = p + q;
    if ((p[DATA_W-1] == q[DATA_W-1]) && (s[DATA_W-1] != p[DATA_W-1])) begin
      s = p[DATA_W-1] ? SMIN : SMAX;
    end
    return s;
  endfunction

  // Saturating subtraction.
  function automatic logic signed [DATA_W-1:0] sat_sub(input logic signed [DATA_W-1:0] p,
                                                       input logic signed [DATA_W-1:0] q);
    logic signed [DATA_W-1:0] d;
    d = p - q;
    if ((p[DATA_W-1] != q[DATA_W-1]) && (d[DATA_W-1] != p[DATA_W-1])) begin
      d = p[DATA_W-1] ? SMIN : SMAX;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/qrs_mul.sv =====
`timescale 1ns / 1ps

module qrs_mul #(
  parameter int B_BITS = 25
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [qrs_pkg::DATA_W-1:0] a,
  input  logic signed [B_BITS-1:0]          b,
  output logic                              done,
  output logic signed [qrs_pkg::DATA_W-1:0] p
);
  import qrs_pkg::*;

  localparam int CW    = 16;
  localparam int NCH   = (B_BITS + CW - 1) / CW;
  localparam int MBW   = NCH * CW;
  localparam int AW    = DATA_W + MBW;
  localparam int CNT_W = $clog2(NCH + 1);

  logic                    run;
  logic                    fin;
  logic [CNT_W-1:0]        cnt;
  logic [DATA_W-1:0]       ma;
  logic [MBW-1:0]          mb;
  logic                    neg;
  logic [AW-1:0]           acc;
  logic [B_BITS-1:0]       b_mag;
  logic [DATA_W+CW-1:0]    pp;
  logic                    ovf_pos;
  logic                    ovf_neg;

  // Magnitude of the narrow operand and one partial product per cycle.
  assign b_mag = b[B_BITS-1] ? B_BITS'(-b) : B_BITS'(b);
  assign pp    = ma * mb[MBW-1 -: CW];

  // Overflow of the magnitude for each sign of the result.
  assign ovf_pos = |acc[AW-1:DATA_W-1];
  assign ovf_neg = (|acc[AW-1:DATA_W]) | (acc[DATA_W-1] & (|acc[DATA_W-2:0]));

  // Multiply the magnitudes a chunk at a time, most significant chunk first,
  // then apply the sign with saturation.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else if (run) begin
      acc <= (acc << CW) + AW'(pp);
      mb  <= mb << CW;
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end else if (fin) begin
      fin  <= 1'b0;
      done <= 1'b1;
      if (neg) begin
        p <= ovf_neg ? SMIN : -$signed(acc[DATA_W-1:0]);
      end else begin
        p <= ovf_pos ? SMAX : $signed(acc[DATA_W-1:0]);
      end
    end else if (start) begin
      ma  <= umag(a);
      mb  <= MBW'(b_mag);
      neg <= a[DATA_W-1] ^ b[B_BITS-1];
      acc <= '0;
      cnt <= CNT_W'(NCH);
      run <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/qrs_div.sv =====
`timescale 1ns / 1ps

module qrs_div #(
  parameter int D_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [qrs_pkg::DATA_W-1:0] num,
  input  logic signed [D_BITS-1:0]          den,
  output logic                              done,
  output logic signed [qrs_pkg::DATA_W-1:0] q
);
  import qrs_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  logic               run;
  logic               fin;
  logic [CNT_W-1:0]   cnt;
  logic [DATA_W-1:0]  nm;
  logic [D_BITS-1:0]  dm;
  logic [D_BITS-1:0]  rem;
  logic               neg;
  logic [D_BITS:0]    trial;
  logic               ge;
  logic [D_BITS-1:0]  den_mag;

  assign den_mag = den[D_BITS-1] ? D_BITS'(-den) : D_BITS'(den);

  // One restoring step: bring down the next numerator bit and try the divisor.
  assign trial = {rem, nm[DATA_W-1]};
  assign ge    = trial >= {1'b0, dm};

  // Divide the magnitudes one quotient bit a cycle, truncating toward zero;
  // the only overflow is the most negative value divided by minus one.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else if (run) begin
      rem <= D_BITS'(ge ? (trial - {1'b0, dm}) : trial);
      nm  <= {nm[DATA_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        run <= 1'b0;
        fin <= 1'b1;
      end
    end else if (fin) begin
      fin  <= 1'b0;
      done <= 1'b1;
      if (neg) begin
        q <= -$signed(nm);
      end else begin
        q <= nm[DATA_W-1] ? SMAX : $signed(nm);
      end
    end else if (start) begin
      nm  <= umag(num);
      dm  <= den_mag;
      rem <= '0;
      neg <= num[DATA_W-1] ^ den[D_BITS-1];
      cnt <= CNT_W'(DATA_W - 1);
      run <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/quadratic_ransac_scorer_unit.sv =====
`timescale 1ns / 1ps
// Sequence: clear and close words go straight to the result; a score word of a bright pixel runs
// three products on the shared multiplier, each of N = ceil((2*COORD_BITS+1)/16) chunk steps;
// a load word is dominated by four 64-step divisions on the shared divider.
// Throughput: one word at a time; the next is taken once the result is registered.
// Reset: synchronous, clears the hypothesis state, best state and output valid;
// tolerance returns to 25 and white level to 20.

module quadratic_ransac_scorer_unit #(
  parameter int COORD_BITS = 12,
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           opcode,
  input  logic [COORD_BITS-1:0]                point1_x,
  input  logic [COORD_BITS-1:0]                point1_y,
  input  logic [COORD_BITS-1:0]                point2_x,
  input  logic [COORD_BITS-1:0]                point2_y,
  input  logic [COORD_BITS-1:0]                point3_x,
  input  logic [COORD_BITS-1:0]                point3_y,
  input  logic [7:0]                           pixel_value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 is_inlier,
  output logic                                 degenerate,
  output logic [COUNT_BITS-1:0]                current_count,
  output logic [COUNT_BITS-1:0]                best_count,
  output logic signed [qrs_pkg::DATA_W-1:0]    best_a,
  output logic signed [qrs_pkg::DATA_W-1:0]    best_b,
  output logic signed [qrs_pkg::DATA_W-1:0]    best_c,
  input  logic                                 cfg_we,
  input  logic [qrs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qrs_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import qrs_pkg::*;

  localparam int D_BITS = COORD_BITS + 1;
  localparam int MB     = 2 * COORD_BITS + 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ISSUE = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  // Micro-steps of the sequencer: the load chain, then the score chain.
  typedef enum logic [4:0] {
    LD_S12, LD_S23, LD_A, LD_YY1, LD_YY2, LD_AD, LD_B, LD_AY1, LD_BY1, LD_C1, LD_C2,
    SC_YY, SC_AYY, SC_BY, SC_SUM1, SC_SUM2, SC_ERR, SC_CMP
  } step_t;

  state_t state;
  step_t  step;

  logic [TOL_W-1:0]   tolerance;
  logic [WHITE_W-1:0] white_level;

  logic signed [DATA_W-1:0] cur_quad, cur_lin, cur_const;
  logic [COUNT_BITS-1:0]    cur_matches;
  logic                     cur_degenerate;
  logic signed [DATA_W-1:0] top_quad, top_lin, top_const;
  logic [COUNT_BITS-1:0]    top_matches;
  logic                     hit;

  logic [COORD_BITS-1:0]    rx1, ry1, rx2, ry2, rx3, ry3;
  logic signed [DATA_W-1:0] t0, t1, t2, t3;

  logic signed [COORD_BITS:0] dx12, dx23, dy12, dy23, dy13;
  logic signed [DATA_W-1:0]   num12, num23, x1f;
  logic [DATA_W-1:0]          limit;

  logic                     mul_start, mul_done;
  logic signed [DATA_W-1:0] mul_a, mul_p;
  logic signed [MB-1:0]     mul_b;
  logic                     div_start, div_done;
  logic signed [DATA_W-1:0] div_num, div_q;
  logic signed [D_BITS-1:0] div_den;

  // Differences of the captured points and their fixed-point forms.
  assign dx12 = $signed({1'b0, rx1}) - $signed({1'b0, rx2});
  assign dx23 = $signed({1'b0, rx2}) - $signed({1'b0, rx3});
  assign dy12 = $signed({1'b0, ry1}) - $signed({1'b0, ry2});
  assign dy23 = $signed({1'b0, ry2}) - $signed({1'b0, ry3});
  assign dy13 = $signed({1'b0, ry1}) - $signed({1'b0, ry3});
  assign num12 = {{(DATA_W-COORD_BITS-1){dx12[COORD_BITS]}}, dx12} <<< FRAC_BITS;
  assign num23 = {{(DATA_W-COORD_BITS-1){dx23[COORD_BITS]}}, dx23} <<< FRAC_BITS;
  assign x1f   = $signed(DATA_W'(rx1)) <<< FRAC_BITS;
  assign limit = DATA_W'({tolerance, {FRAC_BITS{1'b0}}});

  assign in_stall = (state != ST_IDLE);

  // Operand selection for the shared multiplier and divider.
  always_comb begin
    mul_start = 1'b0;
    mul_a     = cur_quad;
    mul_b     = MB'(t1);
    div_start = 1'b0;
    div_num   = num12;
    div_den   = dy12;
    if (state == ST_ISSUE) begin
      case (step)
        LD_S12: begin
          div_start = 1'b1;
        end
        LD_S23: begin
          div_start = 1'b1;
          div_num   = num23;
          div_den   = dy23;
        end
        LD_A: begin
          div_start = 1'b1;
          div_num   = sat_sub(t0, t1);
          div_den   = dy13;
        end
        LD_YY1, SC_YY: begin
          mul_start = 1'b1;
          mul_a     = $signed(DATA_W'(ry1));
          mul_b     = $signed(MB'(ry1));
        end
        LD_YY2: begin
          mul_start = 1'b1;
          mul_a     = $signed(DATA_W'(ry2));
          mul_b     = $signed(MB'(ry2));
        end
        LD_AD: begin
          mul_start = 1'b1;
          mul_b     = MB'(t1 - t2);
        end
        LD_B: begin
          div_start = 1'b1;
          div_num   = sat_sub(num12, t2);
        end
        LD_AY1, SC_AYY: begin
          mul_start = 1'b1;
        end
        LD_BY1, SC_BY: begin
          mul_start = 1'b1;
          mul_a     = cur_lin;
          mul_b     = $signed(MB'(ry1));
        end
        default: begin
        end
      endcase
    end
  end

  qrs_mul #(.B_BITS(MB)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  qrs_div #(.D_BITS(D_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .q     (div_q)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= TOL_RESET;
      white_level <= WHITE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE:   tolerance   <= cfg_data[TOL_W-1:0];
        REG_WHITE_LEVEL: white_level <= cfg_data[WHITE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: takes a word, walks the micro-steps and registers the result word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      step           <= LD_S12;
      out_valid      <= 1'b0;
      hit            <= 1'b0;
      cur_quad       <= '0;
      cur_lin        <= '0;
      cur_const      <= '0;
      cur_matches    <= '0;
      cur_degenerate <= 1'b0;
      top_quad       <= '0;
      top_lin        <= '0;
      top_const      <= '0;
      top_matches    <= '0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            rx1   <= point1_x;
            ry1   <= point1_y;
            rx2   <= point2_x;
            ry2   <= point2_y;
            rx3   <= point3_x;
            ry3   <= point3_y;
            hit   <= 1'b0;
            state <= ST_DONE;
            case (op_t'(opcode))
              OP_CLEAR: begin
                top_quad    <= '0;
                top_lin     <= '0;
                top_const   <= '0;
                top_matches <= '0;
              end
              OP_LOAD: begin
                cur_matches <= '0;
                if ((point1_y == point2_y) || (point1_y == point3_y) ||
                    (point2_y == point3_y)) begin
                  cur_quad       <= '0;
                  cur_lin        <= '0;
                  cur_const      <= '0;
                  cur_degenerate <= 1'b1;
                end else begin
                  cur_degenerate <= 1'b0;
                  step           <= LD_S12;
                  state          <= ST_ISSUE;
                end
              end
              OP_SCORE: begin
                if (pixel_value >= white_level) begin
                  step  <= SC_YY;
                  state <= ST_ISSUE;
                end
              end
              OP_CLOSE: begin
                if (cur_matches >= top_matches) begin
                  top_matches <= cur_matches;
                  top_quad    <= cur_quad;
                  top_lin     <= cur_lin;
                  top_const   <= cur_const;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_ISSUE: begin
          case (step)
            LD_C1: begin
              t2   <= sat_sub(x1f, t2);
              step <= LD_C2;
            end
            LD_C2: begin
              cur_const <= sat_sub(t2, t3);
              state     <= ST_DONE;
            end
            SC_SUM1: begin
              t2   <= sat_add(t2, t3);
              step <= SC_SUM2;
            end
            SC_SUM2: begin
              t2   <= sat_add(t2, cur_const);
              step <= SC_ERR;
            end
            SC_ERR: begin
              t2   <= sat_sub(t2, $signed(DATA_W'(rx1)) <<< FRAC_BITS);
              step <= SC_CMP;
            end
            SC_CMP: begin
              if (umag(t2) < limit) begin
                hit <= 1'b1;
                if (cur_matches != '1) begin
                  cur_matches <= cur_matches + COUNT_BITS'(1);
                end
              end
              state <= ST_DONE;
            end
            default: begin
              state <= ST_WAIT;
            end
          endcase
        end
        ST_WAIT: begin
          if (mul_done || div_done) begin
            case (step)
              LD_S12:          t0       <= div_q;
              LD_S23:          t1       <= div_q;
              LD_A:            cur_quad <= div_q;
              LD_YY1, SC_YY:   t1       <= mul_p;
              LD_YY2, LD_AD:   t2       <= mul_p;
              LD_B:            cur_lin  <= div_q;
              LD_AY1, SC_AYY:  t2       <= mul_p;
              LD_BY1, SC_BY:   t3       <= mul_p;
              default: begin
              end
            endcase
            step  <= step_t'(step + 5'd1);
            state <= ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            is_inlier     <= hit;
            degenerate    <= cur_degenerate;
            current_count <= cur_matches;
            best_count    <= top_matches;
            best_a        <= top_quad;
            best_b        <= top_lin;
            best_c        <= top_const;
            out_valid     <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A degenerate hypothesis always holds zero coefficients.
  assert property (@(posedge clk) disable iff (rst)
    cur_degenerate |-> (cur_quad == '0 && cur_lin == '0 && cur_const == '0))
    else $error("degenerate hypothesis with nonzero coefficients");

  // The shared units are started one at a time and only from the issue state.
  assert property (@(posedge clk) disable iff (rst)
    (mul_start || div_start) |-> (state == ST_ISSUE && !(mul_start && div_start)))
    else $error("arithmetic unit started out of sequence");

  // The sequencer leaves the wait state only on a finished operation.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAIT && !mul_done && !div_done) |=> (state == ST_WAIT))
    else $error("wait state left without a finished operation");

  // An inlier word always reports a nonzero count.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_inlier) |-> (current_count != '0))
    else $error("inlier reported with zero count");

endmodule
